// ===== hdl/dimc_pkg.sv =====
// Package for the delayed interrupt mode controller.
// Holds the bus map, reset constants, input kind codes and the decoded request struct.
// No dependencies; every other file of the block imports it.
`default_nettype none

package dimc_pkg;

    // Default number of interrupt sources (SP, SI, AI, VI, PI, DP).
    localparam int NUM_SOURCES_DEF = 6;

    // Width of the status field on the result channel.
    localparam int IRQ_W = 6;

    // Source number of the DP source, cleared through the mode word.
    localparam int SRC_DP = 5;

    // Bus map.
    localparam logic [31:0] ADDR_MODE    = 32'h0430_0000;
    localparam logic [31:0] ADDR_VERSION = 32'h0430_0004;
    localparam logic [31:0] ADDR_STATUS  = 32'h0430_0008;
    localparam logic [31:0] ADDR_MASK    = 32'h0430_000C;

    localparam logic [31:0] VERSION_RESET = 32'h0202_0102;

    // Bit positions of the mode word as written.
    localparam int MODE_RCOUNT_W   = 7;
    localparam int MODE_REPEAT_CLR = 7;
    localparam int MODE_REPEAT_SET = 8;
    localparam int MODE_EBUS_CLR   = 9;
    localparam int MODE_EBUS_SET   = 10;
    localparam int MODE_DP_CLR     = 11;
    localparam int MODE_UPPER_CLR  = 12;
    localparam int MODE_UPPER_SET  = 13;

    typedef enum logic [2:0] {
        KIND_TICK  = 3'd0,
        KIND_WRITE = 3'd1,
        KIND_READ  = 3'd2,
        KIND_RAISE = 3'd3,
        KIND_CLEAR = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        RD_NONE,
        RD_MODE,
        RD_VERSION,
        RD_STATUS,
        RD_MASK
    } t_rd_sel;

    // Decoded transaction as held in the input register.
    typedef struct packed {
        logic       tick;
        logic       wr_mode;
        logic       wr_mask;
        logic       dp_clear;
        logic       raise;
        logic       clear;
        t_rd_sel    rd_sel;
        logic [2:0] src;
    } t_req;

endpackage : dimc_pkg

`default_nettype wire

// ===== hdl/delayed_interrupt_mode_controller.sv =====
// Top level of the delayed interrupt mode controller.
// Instantiates dimc_in_stage, one dimc_timer_lane per source and dimc_regs; uses dimc_pkg.
// The input channel (i_in_valid / o_in_stall) carries one transaction per
// accepted cycle: a clock tick, a bus write, a bus read, a raise request or a
// clear request. The result channel (o_out_valid / i_out_stall) returns exactly
// one result per transaction, in order: the read data, the status bits after
// the transaction and the pending line (status AND mask nonzero).
// A transaction is captured in the input register at the accepting edge. It is
// evaluated against the state, and its result is loaded into the result
// register and offered, at the first edge at which the result register is free or
// being emptied. One transaction is accepted every cycle unless o_in_stall is high;
// the state update (one 64-bit comparator per source lane, six by default,
// plus the register writes) is combinational between the two registers.
// When the receiver stalls, the result register holds its transaction and the
// input register can still take one more; o_in_stall rises only when both are
// full and the receiver is stalling.
// The version word is written through i_cfg_we / i_cfg_wdata; the user must
// do so only while the block is idle, and the block does not enforce it.
// Reset (synchronous, active low) clears status, mask, mode flags, repeat count
// and every pending entry, empties both registers and restores the default version word.
`default_nettype none

module delayed_interrupt_mode_controller
    import dimc_pkg::*;
#(
    parameter int NUM_SOURCES = NUM_SOURCES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input channel.
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [2:0]  i_kind,
    input  wire logic [31:0] i_address,
    input  wire logic [31:0] i_write_data,
    input  wire logic [2:0]  i_irq_source,
    input  wire logic        i_prev_level,
    input  wire logic        i_new_level,
    input  wire logic [31:0] i_delay,
    input  wire logic [63:0] i_now,
    // Result channel.
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_read_data,
    output logic [IRQ_W-1:0] o_irq_status,
    output logic             o_irq_pending,
    // Configuration port for the version word.
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_wdata
);

    logic                   item_valid;
    t_req                   item_req;
    logic [31:0]            item_data;
    logic [63:0]            item_now;
    logic [63:0]            item_target;

    logic                   out_blocked;
    logic                   adv;
    logic [NUM_SOURCES-1:0] lane_set;
    logic [NUM_SOURCES-1:0] lane_clr;

    // The held transaction moves on whenever the result register is free or
    // being emptied in this cycle. All state updates but the version word happen on that move.
    assign out_blocked = o_out_valid && i_out_stall;
    assign adv         = item_valid && !out_blocked;
    assign o_in_stall  = item_valid && out_blocked;

    dimc_in_stage u_in_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_hold       (o_in_stall),
        .i_in_valid   (i_in_valid),
        .i_kind       (i_kind),
        .i_address    (i_address),
        .i_write_data (i_write_data),
        .i_irq_source (i_irq_source),
        .i_prev_level (i_prev_level),
        .i_new_level  (i_new_level),
        .i_delay      (i_delay),
        .i_now        (i_now),
        .o_valid      (item_valid),
        .o_req        (item_req),
        .o_data       (item_data),
        .o_now        (item_now),
        .o_target     (item_target)
    );

    // One lane per source keeps that source's earliest pending target time.
    for (genvar g = 0; g < NUM_SOURCES; g++) begin : g_lane
        dimc_timer_lane #(
            .LANE (g)
        ) u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_adv    (adv),
            .i_req    (item_req),
            .i_now    (item_now),
            .i_target (item_target),
            .o_set    (lane_set[g]),
            .o_clr    (lane_clr[g])
        );
    end

    dimc_regs #(
        .NUM_SOURCES (NUM_SOURCES)
    ) u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (adv),
        .i_out_stall   (i_out_stall),
        .i_req         (item_req),
        .i_data        (item_data),
        .i_set         (lane_set),
        .i_clr         (lane_clr),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_out_valid   (o_out_valid),
        .o_read_data   (o_read_data),
        .o_irq_status  (o_irq_status),
        .o_irq_pending (o_irq_pending)
    );

endmodule : delayed_interrupt_mode_controller

`default_nettype wire

// ===== hdl/dimc_in_stage.sv =====
// Input register of the delayed interrupt mode controller.
// Decodes the transaction kind and address and forms the saturated target time.
// Depends on dimc_pkg.
`default_nettype none

module dimc_in_stage
    import dimc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_hold,
    input  wire logic        i_in_valid,
    input  wire logic [2:0]  i_kind,
    input  wire logic [31:0] i_address,
    input  wire logic [31:0] i_write_data,
    input  wire logic [2:0]  i_irq_source,
    input  wire logic        i_prev_level,
    input  wire logic        i_new_level,
    input  wire logic [31:0] i_delay,
    input  wire logic [63:0] i_now,
    output logic             o_valid,
    output t_req             o_req,
    output logic [31:0]      o_data,
    output logic [63:0]      o_now,
    output logic [63:0]      o_target
);

    logic        r_valid;
    t_req        r_req;
    logic [31:0] r_data;
    logic [63:0] r_now;
    logic [63:0] r_target;

    t_req        n_req;
    logic [63:0] n_target;
    logic [64:0] sum;

    // A sum past the top of the 64-bit range sticks at the maximum.
    assign sum      = 65'(i_now) + 65'(i_delay);
    assign n_target = sum[64] ? '1 : sum[63:0];

    always_comb begin
        n_req     = '0;
        n_req.rd_sel = RD_NONE;
        n_req.src = i_irq_source;
        case (i_kind)
            KIND_TICK: begin
                n_req.tick = 1'b1;
            end
            KIND_WRITE: begin
                n_req.wr_mode  = (i_address == ADDR_MODE);
                n_req.wr_mask  = (i_address == ADDR_MASK);
                n_req.dp_clear = (i_address == ADDR_MODE) && i_write_data[MODE_DP_CLR];
            end
            KIND_READ: begin
                case (i_address)
                    ADDR_MODE:    n_req.rd_sel = RD_MODE;
                    ADDR_VERSION: n_req.rd_sel = RD_VERSION;
                    ADDR_STATUS:  n_req.rd_sel = RD_STATUS;
                    ADDR_MASK:    n_req.rd_sel = RD_MASK;
                    default:      n_req.rd_sel = RD_NONE;
                endcase
            end
            KIND_RAISE: begin
                n_req.raise = !i_prev_level && i_new_level;
            end
            KIND_CLEAR: begin
                n_req.clear = 1'b1;
            end
            default: begin
                n_req.rd_sel = RD_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!i_hold) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !i_hold) begin
            r_req    <= n_req;
            r_data   <= i_write_data;
            r_now    <= i_now;
            r_target <= n_target;
        end
    end

    assign o_valid  = r_valid;
    assign o_req    = r_req;
    assign o_data   = r_data;
    assign o_now    = r_now;
    assign o_target = r_target;

endmodule : dimc_in_stage

`default_nettype wire

// ===== hdl/dimc_timer_lane.sv =====
// One pending-time lane of the delayed interrupt mode controller.
// Keeps the earliest target time of one source and flags it due on a tick.
// Depends on dimc_pkg.
`default_nettype none

module dimc_timer_lane
    import dimc_pkg::*;
#(
    parameter int LANE = 0
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_adv,
    input  wire t_req        i_req,
    input  wire logic [63:0] i_now,
    input  wire logic [63:0] i_target,
    output logic             o_set,
    output logic             o_clr
);

    localparam logic [4:0] LaneId = 5'(LANE);
    localparam logic [4:0] DpId   = 5'(SRC_DP);

    logic        r_valid;
    logic [63:0] r_target;
    logic        n_valid;
    logic [63:0] n_target;

    logic        hit;
    logic [63:0] key;
    logic        lt;
    logic        due;
    logic        raise;
    logic        drop;

    assign hit   = (5'(i_req.src) == LaneId);
    // One comparator serves both the tick check and the earlier-time check of a raise.
    assign key   = i_req.tick ? i_now : i_target;
    assign lt    = (key < r_target);
    assign due   = i_req.tick && r_valid && !lt;
    assign raise = i_req.raise && hit;
    assign drop  = (i_req.clear && hit) || (i_req.dp_clear && (LaneId == DpId));

    always_comb begin
        n_valid  = r_valid;
        n_target = r_target;
        if (raise) begin
            n_valid = 1'b1;
            if (!r_valid || lt) begin
                n_target = i_target;
            end
        end
        if (drop || due) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_target <= n_target;
        end
    end

    assign o_set = due;
    assign o_clr = drop;

endmodule : dimc_timer_lane

`default_nettype wire

// ===== hdl/dimc_regs.sv =====
// Status, mask, mode and version registers of the delayed interrupt mode controller,
// with the bus read mux and the result register. Depends on dimc_pkg.
`default_nettype none

module dimc_regs
    import dimc_pkg::*;
#(
    parameter int NUM_SOURCES = NUM_SOURCES_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_adv,
    input  wire logic                   i_out_stall,
    input  wire t_req                   i_req,
    input  wire logic [31:0]            i_data,
    input  wire logic [NUM_SOURCES-1:0] i_set,
    input  wire logic [NUM_SOURCES-1:0] i_clr,
    input  wire logic                   i_cfg_we,
    input  wire logic [31:0]            i_cfg_wdata,
    output logic                        o_out_valid,
    output logic [31:0]                 o_read_data,
    output logic [IRQ_W-1:0]            o_irq_status,
    output logic                        o_irq_pending
);

    localparam int PadW = (NUM_SOURCES > IRQ_W) ? NUM_SOURCES : IRQ_W;

    logic [NUM_SOURCES-1:0]   r_status;
    logic [NUM_SOURCES-1:0]   r_mask;
    logic [MODE_RCOUNT_W-1:0] r_rcount;
    logic                     r_repeat;
    logic                     r_ebus;
    logic                     r_upper;
    logic [31:0]              r_version;

    logic                     r_out_valid;
    logic [31:0]              r_read_data;
    logic [IRQ_W-1:0]         r_irq_status;
    logic                     r_irq_pending;

    logic [NUM_SOURCES-1:0]   n_status;
    logic [NUM_SOURCES-1:0]   n_mask;
    logic [MODE_RCOUNT_W-1:0] n_rcount;
    logic                     n_repeat;
    logic                     n_ebus;
    logic                     n_upper;
    logic                     n_out_valid;
    logic [31:0]              rd_data;
    logic [PadW-1:0]          status_pad;

    assign n_status = (r_status | i_set) & ~i_clr;

    always_comb begin
        n_mask = r_mask;
        if (i_req.wr_mask) begin
            for (int i = 0; i < NUM_SOURCES; i++) begin
                if (i_data[2*i]) begin
                    n_mask[i] = 1'b0;
                end
                if (i_data[2*i+1]) begin
                    n_mask[i] = 1'b1;
                end
            end
        end
    end

    // Set wins over clear for each flag of the mode word.
    always_comb begin
        n_rcount = r_rcount;
        n_repeat = r_repeat;
        n_ebus   = r_ebus;
        n_upper  = r_upper;
        if (i_req.wr_mode) begin
            n_rcount = i_data[MODE_RCOUNT_W-1:0];
            n_repeat = i_data[MODE_REPEAT_SET] | (r_repeat & ~i_data[MODE_REPEAT_CLR]);
            n_ebus   = i_data[MODE_EBUS_SET]   | (r_ebus   & ~i_data[MODE_EBUS_CLR]);
            n_upper  = i_data[MODE_UPPER_SET]  | (r_upper  & ~i_data[MODE_UPPER_CLR]);
        end
    end

    always_comb begin
        case (i_req.rd_sel)
            RD_MODE:    rd_data = {22'd0, r_upper, r_ebus, r_repeat, r_rcount};
            RD_VERSION: rd_data = r_version;
            RD_STATUS:  rd_data = 32'(r_status);
            RD_MASK:    rd_data = 32'(r_mask);
            default:    rd_data = '0;
        endcase
    end

    assign status_pad = PadW'(n_status);

    always_comb begin
        if (i_adv) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status    <= '0;
            r_mask      <= '0;
            r_rcount    <= '0;
            r_repeat    <= 1'b0;
            r_ebus      <= 1'b0;
            r_upper     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (i_adv) begin
                r_status <= n_status;
                r_mask   <= n_mask;
                r_rcount <= n_rcount;
                r_repeat <= n_repeat;
                r_ebus   <= n_ebus;
                r_upper  <= n_upper;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_version <= VERSION_RESET;
        end else if (i_cfg_we) begin
            r_version <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_read_data   <= rd_data;
            r_irq_status  <= status_pad[IRQ_W-1:0];
            r_irq_pending <= |(n_status & n_mask);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_read_data   = r_read_data;
    assign o_irq_status  = r_irq_status;
    assign o_irq_pending = r_irq_pending;

endmodule : dimc_regs

`default_nettype wire

// ===== hdl/dimc_checker.sv =====
// Port-level checker for the delayed interrupt mode controller, bound to the top level.
// Depends on dimc_pkg and on delayed_interrupt_mode_controller.
`default_nettype none

module dimc_checker
    import dimc_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             o_in_stall,
    input wire logic             o_out_valid,
    input wire logic             i_out_stall,
    input wire logic [IRQ_W-1:0] o_irq_status,
    input wire logic             o_irq_pending
);

    // A reset empties the result register.
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered right after reset");

    // The input side only backs up when a result is waiting on a stalled receiver.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a blocked result");

    // The pending line can only be high when some status bit is set.
    a_pending_needs_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_irq_pending) |-> (o_irq_status != '0))
        else $error("pending line high with empty status");

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("stalled result withdrawn");

endmodule : dimc_checker

bind delayed_interrupt_mode_controller dimc_checker u_dimc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_irq_status  (o_irq_status),
    .o_irq_pending (o_irq_pending)
);

`default_nettype wire
